FILE: rtl/spims_pkg.sv
package spims_pkg;

   // Default word length of the shifter (eight bits).
   localparam int DATA_BITS_DEFAULT = 8;

   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int BIT_CNT_W  = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_POLARITY  = 3'd0,
      CSR_CLOCK_PHASE     = 3'd1,
      CSR_LSB_FIRST       = 3'd2,
      CSR_BAUD_DIVIDER    = 3'd3,
      CSR_RECEIVER_ENABLE = 3'd4
   } csr_index_type;

   // Status flags as seen by software.
   typedef struct packed {
      logic overflow;
      logic transmit_complete;
      logic receive_complete;
   } status_type;

endpackage

FILE: rtl/spi_master_byte_shifter_unit.sv
// Channel  Direction  Payload
// req_     in         tdata: write_strobe[0], write_byte[8:1], read_strobe[9], miso[10]
// rsp_     out        tdata: sck[0], mosi[1], rx_byte[9:2], data_register_empty[10],
//                            receive_complete[11], transmit_complete[12], overflow[13]
// csr_     in         csr_index selects the register, csr_data carries the value
//
// Each request item is one system clock step of the SPI engine and produces exactly
// one response item in the cycle after it is accepted. An item may be accepted on
// every cycle; the only limit is the single output register, which must be free or
// emptying in the same cycle. Reset is synchronous and active high; it returns the
// engine to idle with SCK at the polarity setting and all status flags clear, and
// the receiver enabled. A stalled response simply holds the engine still, because
// the engine only advances when a request item is accepted.
module spi_master_byte_shifter_unit
   import spims_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // write_strobe[0], write_byte[8:1], read_strobe[9], miso[10], zero above
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sck[0], mosi[1], rx_byte[9:2], data_register_empty[10], receive_complete[11],
   // transmit_complete[12], overflow[13], zero above
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Final bit count of a word, at the counter's width.
   localparam logic [BIT_CNT_W-1:0] LastCount = BIT_CNT_W'(DATA_BITS);

   // Configuration registers.
   logic                  clock_polarity_ff;
   logic                  clock_phase_ff;
   logic                  lsb_first_ff;
   logic [BYTE_W-1:0]     baud_divider_ff;
   logic                  receiver_enable_ff;

   // Engine state.
   logic [DATA_BITS-1:0]  holding_byte_ff, holding_byte_in;
   logic                  holding_full_ff, holding_full_in;
   logic [DATA_BITS-1:0]  shift_byte_ff,   shift_byte_in;
   logic [BIT_CNT_W-1:0]  bit_counter_ff,  bit_counter_in;
   logic [BYTE_W-1:0]     half_count_ff,   half_count_in;
   logic                  clock_level_ff,  clock_level_in;
   logic                  shifting_ff,     shifting_in;
   logic [BYTE_W-1:0]     received_byte_ff, received_byte_in;
   status_type            status_ff,       status_in;
   logic                  sample_latch_ff, sample_latch_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   logic                  req_accept;
   logic                  write_strobe;
   logic [BYTE_W-1:0]     write_byte;
   logic                  read_strobe;
   logic                  miso;
   logic [BIT_CNT_W-1:0]  bit_count_next;
   logic                  sck;
   logic                  mosi;

   assign write_strobe = req_tdata[0];
   assign write_byte   = req_tdata[8:1];
   assign read_strobe  = req_tdata[9];
   assign miso         = req_tdata[10];

   // The output register is free when it is empty or being emptied this cycle.
   // Nothing is taken on either channel while reset is held.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_polarity_ff  <= 1'b0;
         clock_phase_ff     <= 1'b0;
         lsb_first_ff       <= 1'b0;
         baud_divider_ff    <= '0;
         receiver_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_POLARITY:  clock_polarity_ff  <= csr_data[0];
            CSR_CLOCK_PHASE:     clock_phase_ff     <= csr_data[0];
            CSR_LSB_FIRST:       lsb_first_ff       <= csr_data[0];
            CSR_BAUD_DIVIDER:    baud_divider_ff    <= csr_data;
            CSR_RECEIVER_ENABLE: receiver_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // One engine step. Order within the step: read, write, shift engine, then the
   // transfer from the holding register into an idle shifter.
   always_comb begin
      holding_byte_in  = holding_byte_ff;
      holding_full_in  = holding_full_ff;
      shift_byte_in    = shift_byte_ff;
      bit_counter_in   = bit_counter_ff;
      half_count_in    = half_count_ff;
      clock_level_in   = clock_level_ff;
      shifting_in      = shifting_ff;
      received_byte_in = received_byte_ff;
      status_in        = status_ff;
      sample_latch_in  = sample_latch_ff;
      bit_count_next   = bit_counter_ff + 1'b1;

      if (read_strobe) begin
         status_in.receive_complete = 1'b0;
      end

      // A write while the holding register is full is dropped silently.
      if (write_strobe && !holding_full_ff) begin
         holding_byte_in             = DATA_BITS'(write_byte);
         holding_full_in             = 1'b1;
         status_in.transmit_complete = 1'b0;
      end

      if (shifting_ff) begin
         if (half_count_ff < baud_divider_ff) begin
            half_count_in = half_count_ff + 1'b1;
         end else begin
            half_count_in = '0;
            if (!clock_level_ff) begin
               // Entering the second half of the bit: sample MISO.
               clock_level_in  = 1'b1;
               sample_latch_in = miso;
            end else begin
               clock_level_in = 1'b0;
               if (lsb_first_ff) begin
                  shift_byte_in = {sample_latch_ff, shift_byte_ff[DATA_BITS-1:1]};
               end else begin
                  shift_byte_in = {shift_byte_ff[DATA_BITS-2:0], sample_latch_ff};
               end
               bit_counter_in = bit_count_next;
               if (bit_count_next >= LastCount) begin
                  shifting_in = 1'b0;
                  // With the receiver on, an unread byte is kept and the new one
                  // is counted as an overflow instead.
                  if (receiver_enable_ff) begin
                     if (status_in.receive_complete) begin
                        status_in.overflow = 1'b1;
                     end else begin
                        received_byte_in           = shift_byte_in[BYTE_W-1:0];
                        status_in.receive_complete = 1'b1;
                     end
                  end
                  if (!holding_full_in) begin
                     status_in.transmit_complete = 1'b1;
                  end
               end
            end
         end
      end

      if (!shifting_in && holding_full_in) begin
         shift_byte_in   = holding_byte_in;
         holding_full_in = 1'b0;
         shifting_in     = 1'b1;
         bit_counter_in  = '0;
         half_count_in   = '0;
         clock_level_in  = 1'b0;
      end

      // Pins: SCK rests at the polarity level and MOSI low while idle.
      if (shifting_in) begin
         sck  = clock_polarity_ff ^ clock_phase_ff ^ clock_level_in;
         mosi = lsb_first_ff ? shift_byte_in[0] : shift_byte_in[DATA_BITS-1];
      end else begin
         sck  = clock_polarity_ff;
         mosi = 1'b0;
      end

      rsp_data_in = {2'b00, status_in.overflow, status_in.transmit_complete,
                     status_in.receive_complete, !holding_full_in, received_byte_in,
                     mosi, sck};
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_full_ff  <= 1'b0;
         bit_counter_ff   <= '0;
         half_count_ff    <= '0;
         clock_level_ff   <= 1'b0;
         shifting_ff      <= 1'b0;
         received_byte_ff <= '0;
         status_ff        <= '0;
         sample_latch_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            holding_full_ff  <= holding_full_in;
            bit_counter_ff   <= bit_counter_in;
            half_count_ff    <= half_count_in;
            clock_level_ff   <= clock_level_in;
            shifting_ff      <= shifting_in;
            received_byte_ff <= received_byte_in;
            status_ff        <= status_in;
            sample_latch_ff  <= sample_latch_in;
         end
      end
   end

   // Data path registers carry no reset; they are loaded before they are shown.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         holding_byte_ff <= holding_byte_in;
         shift_byte_ff   <= shift_byte_in;
         rsp_data_ff     <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
